// ----- rtl/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Shared widths and beat types for the swept circle-circle collision test.
// ----------------------------------------------------------------------------
package cst_pkg;

   // field widths
   localparam int CoordWidth  = 16;
   localparam int RadiusWidth = CoordWidth - 1;
   localparam int TimeWidth   = 32;
   localparam int FracBits    = 16;

   // internal widths, all from the coordinate width
   localparam int DiffWidth   = CoordWidth + 1;
   localparam int VelWidth    = CoordWidth + 3;
   localparam int DistWidth   = 2 * CoordWidth + 2;
   localparam int AWidth      = 2 * CoordWidth + 6;
   localparam int HMagWidth   = 2 * CoordWidth + 4;
   localparam int ProdWidth   = 4 * CoordWidth + 8;
   localparam int RootWidth   = ProdWidth / 2;
   localparam int NumWidth    = 2 * CoordWidth + 6;
   localparam int QuoWidth    = NumWidth + FracBits;

   typedef struct packed {
      logic signed [CoordWidth-1:0] a_start_x;
      logic signed [CoordWidth-1:0] a_start_y;
      logic signed [CoordWidth-1:0] a_end_x;
      logic signed [CoordWidth-1:0] a_end_y;
      logic [RadiusWidth-1:0]       a_radius;
      logic signed [CoordWidth-1:0] b_start_x;
      logic signed [CoordWidth-1:0] b_start_y;
      logic signed [CoordWidth-1:0] b_end_x;
      logic signed [CoordWidth-1:0] b_end_y;
      logic [RadiusWidth-1:0]       b_radius;
   } req_type;

   typedef struct packed {
      logic                        hit;
      logic signed [TimeWidth-1:0] first_time;
      logic signed [TimeWidth-1:0] second_time;
   } rsp_type;

   // what the front end hands on next to the discriminant
   typedef struct packed {
      logic                 overlap;
      logic                 hit;
      logic                 h_neg;
      logic [HMagWidth-1:0] h_mag;
      logic [AWidth-1:0]    a;
   } front_side_type;

endpackage

// ----- rtl/cst_front.sv -----
// ----------------------------------------------------------------------------
// cst_front
// Seven-stage front end: differences, products, distances, quadratic terms
// and the discriminant.
// ----------------------------------------------------------------------------
module cst_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  cst_pkg::req_type           in_data,
   output logic                       out_valid,
   output logic [cst_pkg::ProdWidth-1:0] out_disc,
   output cst_pkg::front_side_type    out_side
);
   import cst_pkg::*;

   localparam int HWidth = HMagWidth + 1;
   localparam int HLo    = HMagWidth / 2;
   localparam int HHi    = HMagWidth - HLo;
   localparam int ALo    = AWidth / 2;
   localparam int AHi    = AWidth - ALo;
   localparam int CLo    = DistWidth / 2;
   localparam int CHi    = DistWidth - CLo;

   logic [6:0] valid_ff;

   // stage 1: differences
   logic signed [DiffWidth-1:0] abx_ff, aby_ff, ab1x_ff, ab1y_ff;
   logic signed [VelWidth-1:0]  vx_ff, vy_ff;
   logic [CoordWidth-1:0]       rab_ff;
   // stage 2: products
   logic signed [2*DiffWidth-1:0]        abx2_ff, aby2_ff, ab1x2_ff, ab1y2_ff;
   logic signed [2*VelWidth-1:0]         vx2_ff, vy2_ff;
   logic signed [VelWidth+DiffWidth-1:0] vxab_ff, vyab_ff;
   logic [2*CoordWidth-1:0]              rab2_ff;
   // stage 3: sums
   logic [DistWidth-1:0]    d0_ff, d1_ff, r2_ff;
   logic [AWidth-1:0]       a3_ff;
   logic signed [HWidth-1:0] h_ff;
   // stage 4: overlap and magnitudes
   logic                 ovl4_ff, hneg4_ff;
   logic [HMagWidth-1:0] hmag4_ff;
   logic [DistWidth-1:0] c4_ff;
   logic [AWidth-1:0]    a4_ff;
   // stage 5: partial products
   logic [2*HHi-1:0]     phh_ff;
   logic [HHi+HLo-1:0]   phl_ff;
   logic [2*HLo-1:0]     pll_ff;
   logic [AHi+CHi-1:0]   qhh_ff;
   logic [AHi+CLo-1:0]   qhl_ff;
   logic [ALo+CHi-1:0]   qlh_ff;
   logic [ALo+CLo-1:0]   qll_ff;
   logic                 ovl5_ff, hneg5_ff;
   logic [HMagWidth-1:0] hmag5_ff;
   logic [AWidth-1:0]    a5_ff;
   // stage 6: full squares
   logic [ProdWidth-1:0] h2_ff, ac_ff;
   logic                 ovl6_ff, hneg6_ff;
   logic [HMagWidth-1:0] hmag6_ff;
   logic [AWidth-1:0]    a6_ff;
   // stage 7: discriminant
   logic [ProdWidth-1:0] disc_ff;
   front_side_type       side_ff;

   logic [ProdWidth-1:0] h2_in, ac_in;
   logic                 nohit_in;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      abx_ff  <= DiffWidth'(in_data.b_start_x) - DiffWidth'(in_data.a_start_x);
      aby_ff  <= DiffWidth'(in_data.b_start_y) - DiffWidth'(in_data.a_start_y);
      ab1x_ff <= DiffWidth'(in_data.b_end_x) - DiffWidth'(in_data.a_end_x);
      ab1y_ff <= DiffWidth'(in_data.b_end_y) - DiffWidth'(in_data.a_end_y);
      vx_ff   <= VelWidth'(in_data.b_end_x) - VelWidth'(in_data.b_start_x)
               - VelWidth'(in_data.a_end_x) + VelWidth'(in_data.a_start_x);
      vy_ff   <= VelWidth'(in_data.b_end_y) - VelWidth'(in_data.b_start_y)
               - VelWidth'(in_data.a_end_y) + VelWidth'(in_data.a_start_y);
      rab_ff  <= CoordWidth'(in_data.a_radius) + CoordWidth'(in_data.b_radius);
   end

   // stage 2
   always_ff @(posedge clock) begin
      abx2_ff  <= abx_ff * abx_ff;
      aby2_ff  <= aby_ff * aby_ff;
      ab1x2_ff <= ab1x_ff * ab1x_ff;
      ab1y2_ff <= ab1y_ff * ab1y_ff;
      vx2_ff   <= vx_ff * vx_ff;
      vy2_ff   <= vy_ff * vy_ff;
      vxab_ff  <= vx_ff * abx_ff;
      vyab_ff  <= vy_ff * aby_ff;
      rab2_ff  <= rab_ff * rab_ff;
   end

   // stage 3
   always_ff @(posedge clock) begin
      d0_ff <= DistWidth'($unsigned(abx2_ff)) + DistWidth'($unsigned(aby2_ff));
      d1_ff <= DistWidth'($unsigned(ab1x2_ff)) + DistWidth'($unsigned(ab1y2_ff));
      r2_ff <= DistWidth'(rab2_ff);
      a3_ff <= AWidth'($unsigned(vx2_ff)) + AWidth'($unsigned(vy2_ff));
      h_ff  <= HWidth'(vxab_ff) + HWidth'(vyab_ff);
   end

   // stage 4
   always_ff @(posedge clock) begin
      ovl4_ff  <= (d0_ff <= r2_ff) || (d1_ff <= r2_ff);
      c4_ff    <= d0_ff - r2_ff;
      hneg4_ff <= h_ff[HWidth-1];
      hmag4_ff <= h_ff[HWidth-1] ? HMagWidth'(-h_ff) : HMagWidth'(h_ff);
      a4_ff    <= a3_ff;
   end

   // stage 5: split squares into narrow partial products
   always_ff @(posedge clock) begin
      phh_ff   <= hmag4_ff[HMagWidth-1:HLo] * hmag4_ff[HMagWidth-1:HLo];
      phl_ff   <= hmag4_ff[HMagWidth-1:HLo] * hmag4_ff[HLo-1:0];
      pll_ff   <= hmag4_ff[HLo-1:0] * hmag4_ff[HLo-1:0];
      qhh_ff   <= a4_ff[AWidth-1:ALo] * c4_ff[DistWidth-1:CLo];
      qhl_ff   <= a4_ff[AWidth-1:ALo] * c4_ff[CLo-1:0];
      qlh_ff   <= a4_ff[ALo-1:0] * c4_ff[DistWidth-1:CLo];
      qll_ff   <= a4_ff[ALo-1:0] * c4_ff[CLo-1:0];
      ovl5_ff  <= ovl4_ff;
      hneg5_ff <= hneg4_ff;
      hmag5_ff <= hmag4_ff;
      a5_ff    <= a4_ff;
   end

   // stage 6: recombine
   assign h2_in = (ProdWidth'(phh_ff) << (2 * HLo)) + (ProdWidth'(phl_ff) << (HLo + 1))
                + ProdWidth'(pll_ff);
   assign ac_in = (ProdWidth'(qhh_ff) << (ALo + CLo)) + (ProdWidth'(qhl_ff) << ALo)
                + (ProdWidth'(qlh_ff) << CLo) + ProdWidth'(qll_ff);

   always_ff @(posedge clock) begin
      h2_ff    <= h2_in;
      ac_ff    <= ac_in;
      ovl6_ff  <= ovl5_ff;
      hneg6_ff <= hneg5_ff;
      hmag6_ff <= hmag5_ff;
      a6_ff    <= a5_ff;
   end

   // stage 7: discriminant and hit decision
   assign nohit_in = (a6_ff == '0) || (h2_ff < ac_ff);

   always_ff @(posedge clock) begin
      disc_ff         <= h2_ff - ac_ff;
      side_ff.overlap <= ovl6_ff;
      side_ff.hit     <= ovl6_ff || !nohit_in;
      side_ff.h_neg   <= hneg6_ff;
      side_ff.h_mag   <= hmag6_ff;
      side_ff.a       <= a6_ff;
   end

   assign out_valid = valid_ff[6];
   assign out_disc  = disc_ff;
   assign out_side  = side_ff;

endmodule

// ----- rtl/cst_sqrt.sv -----
// ----------------------------------------------------------------------------
// cst_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cst_sqrt #(
   parameter int RAD_WIDTH  = 72,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [RAD_WIDTH-1:0]    in_rad,
   input  logic [SIDE_WIDTH-1:0]   in_side,
   output logic                    out_valid,
   output logic [RAD_WIDTH/2-1:0]  out_root,
   output logic [SIDE_WIDTH-1:0]   out_side
);
   import cst_pkg::*;

   localparam int Steps = RAD_WIDTH / 2;

   logic                  valid_ff [Steps];
   logic [RAD_WIDTH-1:0]  rad_ff   [Steps];
   logic [Steps+1:0]      rem_ff   [Steps];
   logic [Steps-1:0]      root_ff  [Steps];
   logic [SIDE_WIDTH-1:0] side_ff  [Steps];

   for (genvar g = 0; g < Steps; g++) begin : g_step
      logic                  valid_src;
      logic [RAD_WIDTH-1:0]  rad_src;
      logic [Steps+1:0]      rem_src;
      logic [Steps-1:0]      root_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic [Steps+3:0]      trial;
      logic [Steps+3:0]      cand;
      logic                  take;

      if (g == 0) begin : g_first
         assign valid_src = in_valid;
         assign rad_src   = in_rad;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[g-1];
         assign rad_src   = rad_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign root_src  = root_ff[g-1];
         assign side_src  = side_ff[g-1];
      end

      // bring down two radicand bits, try root bit one
      assign cand  = {rem_src, rad_src[RAD_WIDTH-1 -: 2]};
      assign trial = (Steps+4)'({root_src, 2'b01});
      assign take  = cand >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= rad_src << 2;
         rem_ff[g]  <= take ? (Steps+2)'(cand - trial) : (Steps+2)'(cand);
         root_ff[g] <= {root_src[Steps-2:0], take};
         side_ff[g] <= side_src;
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_root  = root_ff[Steps-1];
   assign out_side  = side_ff[Steps-1];

endmodule

// ----- rtl/cst_div.sv -----
// ----------------------------------------------------------------------------
// cst_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cst_div #(
   parameter int NUM_WIDTH  = 54,
   parameter int DEN_WIDTH  = 38,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [NUM_WIDTH-1:0]  in_num,
   input  logic [DEN_WIDTH-1:0]  in_den,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic [NUM_WIDTH-1:0]  out_quo,
   output logic                  out_rem_nz,
   output logic [SIDE_WIDTH-1:0] out_side
);
   import cst_pkg::*;

   logic                  valid_ff [NUM_WIDTH];
   logic [NUM_WIDTH-1:0]  dq_ff    [NUM_WIDTH];
   logic [DEN_WIDTH-1:0]  rem_ff   [NUM_WIDTH];
   logic [DEN_WIDTH-1:0]  den_ff   [NUM_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff  [NUM_WIDTH];

   for (genvar g = 0; g < NUM_WIDTH; g++) begin : g_step
      logic                  valid_src;
      logic [NUM_WIDTH-1:0]  dq_src;
      logic [DEN_WIDTH-1:0]  rem_src;
      logic [DEN_WIDTH-1:0]  den_src;
      logic [SIDE_WIDTH-1:0] side_src;
      logic [DEN_WIDTH:0]    part;
      logic                  take;

      if (g == 0) begin : g_first
         assign valid_src = in_valid;
         assign dq_src    = in_num;
         assign rem_src   = '0;
         assign den_src   = in_den;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[g-1];
         assign dq_src    = dq_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign side_src  = side_ff[g-1];
      end

      // shift in the next dividend bit, subtract if it fits
      assign part = {rem_src, dq_src[NUM_WIDTH-1]};
      assign take = part >= (DEN_WIDTH+1)'(den_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         dq_ff[g]   <= {dq_src[NUM_WIDTH-2:0], take};
         rem_ff[g]  <= take ? DEN_WIDTH'(part - (DEN_WIDTH+1)'(den_src)) : DEN_WIDTH'(part);
         den_ff[g]  <= den_src;
         side_ff[g] <= side_src;
      end
   end

   assign out_valid  = valid_ff[NUM_WIDTH-1];
   assign out_quo    = dq_ff[NUM_WIDTH-1];
   assign out_rem_nz = |rem_ff[NUM_WIDTH-1];
   assign out_side   = side_ff[NUM_WIDTH-1];

endmodule

// ----- rtl/moving_circle_sweep_test_core.sv -----
// ----------------------------------------------------------------------------
// moving_circle_sweep_test_core
// Swept circle-circle collision test: hit flag and two contact times.
// ----------------------------------------------------------------------------
// Usage:
//   An item (two circles, start and end centers, radii, signed Q11.4) is taken
//   at a clock edge with start high and busy low. busy is high only in reset.
//   Exactly one result beat comes back on rsp_data with rsp_strobe high for
//   one cycle: hit plus first_time <= second_time in signed Q15.16, saturated.
//   Overlap at either end gives hit with both times zero; no real root or no
//   relative motion gives no hit with both times zero.
//   Stages: 7 front end (differences, products, sums, magnitudes, partial
//   products of wide squares, recombination, discriminant), 36 square root
//   (one root bit each), 1 numerator, 54 divider (one quotient bit each), 1
//   rounding, 1 saturation. Throughput is one item per cycle while busy is
//   low; results leave in the order taken.
//   Reset clears all valid bits, so in-flight items are dropped.
//   The receiver cannot stall; every result is shown exactly once.
// ----------------------------------------------------------------------------
module moving_circle_sweep_test_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cst_pkg::req_type req_data,
   output logic             rsp_strobe,
   output cst_pkg::rsp_type rsp_data
);
   import cst_pkg::*;

   localparam int Latency = 7 + RootWidth + 1 + QuoWidth + 2;
   localparam int SideWidth = $bits(front_side_type);

   logic                 in_valid;
   logic                 fr_valid;
   logic [ProdWidth-1:0] fr_disc;
   front_side_type       fr_side;
   logic                 sq_valid;
   logic [RootWidth-1:0] sq_root;
   logic [SideWidth-1:0] sq_side_bits;
   front_side_type       sq_side;

   logic signed [NumWidth:0] nh_in, n1_in, n2_in;
   logic                     num_valid_ff;
   logic                     neg1_ff, neg2_ff, hit_ff, ovl_ff;
   logic [NumWidth-1:0]      mag1_ff, mag2_ff;
   logic [AWidth-1:0]        a_ff;

   logic                d1_valid, d2_valid;
   logic [QuoWidth-1:0] q1, q2;
   logic                r1_nz, r2_nz;
   logic [2:0]          d1_side;
   logic                d2_side;

   logic                rnd_valid_ff, rnd_neg1_ff, rnd_neg2_ff, rnd_zero_ff, rnd_hit_ff;
   logic [QuoWidth-1:0] rnd_q1_ff, rnd_q2_ff;

   logic [QuoWidth-1:0]  lim1, lim2, sat1, sat2;
   logic [TimeWidth-1:0] t1_in, t2_in;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_data_ff;

   assign busy     = reset;
   assign in_valid = start && !busy;

   cst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_disc  (fr_disc),
      .out_side  (fr_side)
   );

   cst_sqrt #(
      .RAD_WIDTH  (ProdWidth),
      .SIDE_WIDTH (SideWidth)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_rad    (fr_disc),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_bits)
   );

   assign sq_side = front_side_type'(sq_side_bits);

   // numerators -h - s and -h + s as sign and magnitude
   assign nh_in = sq_side.h_neg ? (NumWidth+1)'(sq_side.h_mag)
                                : -(NumWidth+1)'(sq_side.h_mag);
   assign n1_in = nh_in - (NumWidth+1)'(sq_root);
   assign n2_in = nh_in + (NumWidth+1)'(sq_root);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else begin
         num_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff <= n1_in[NumWidth];
      neg2_ff <= n2_in[NumWidth];
      mag1_ff <= n1_in[NumWidth] ? NumWidth'(-n1_in) : NumWidth'(n1_in);
      mag2_ff <= n2_in[NumWidth] ? NumWidth'(-n2_in) : NumWidth'(n2_in);
      a_ff    <= sq_side.a;
      hit_ff  <= sq_side.hit;
      ovl_ff  <= sq_side.overlap;
   end

   cst_div #(
      .NUM_WIDTH  (QuoWidth),
      .DEN_WIDTH  (AWidth),
      .SIDE_WIDTH (3)
   ) u_div_first (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (num_valid_ff),
      .in_num     ({mag1_ff, FracBits'(0)}),
      .in_den     (a_ff),
      .in_side    ({ovl_ff, hit_ff, neg1_ff}),
      .out_valid  (d1_valid),
      .out_quo    (q1),
      .out_rem_nz (r1_nz),
      .out_side   (d1_side)
   );

   cst_div #(
      .NUM_WIDTH  (QuoWidth),
      .DEN_WIDTH  (AWidth),
      .SIDE_WIDTH (1)
   ) u_div_second (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (num_valid_ff),
      .in_num     ({mag2_ff, FracBits'(0)}),
      .in_den     (a_ff),
      .in_side    (neg2_ff),
      .out_valid  (d2_valid),
      .out_quo    (q2),
      .out_rem_nz (r2_nz),
      .out_side   (d2_side)
   );

   // floor for negative quotients: round magnitude up on a remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else begin
         rnd_valid_ff <= d1_valid && d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      rnd_q1_ff   <= q1 + QuoWidth'(d1_side[0] && r1_nz);
      rnd_q2_ff   <= q2 + QuoWidth'(d2_side && r2_nz);
      rnd_neg1_ff <= d1_side[0];
      rnd_neg2_ff <= d2_side;
      rnd_zero_ff <= d1_side[2] || !d1_side[1];
      rnd_hit_ff  <= d1_side[1];
   end

   // saturate and restore the sign
   assign lim1  = (QuoWidth'(1) << (TimeWidth - 1)) - QuoWidth'(!rnd_neg1_ff);
   assign lim2  = (QuoWidth'(1) << (TimeWidth - 1)) - QuoWidth'(!rnd_neg2_ff);
   assign sat1  = (rnd_q1_ff > lim1) ? lim1 : rnd_q1_ff;
   assign sat2  = (rnd_q2_ff > lim2) ? lim2 : rnd_q2_ff;
   assign t1_in = rnd_neg1_ff ? -TimeWidth'(sat1) : TimeWidth'(sat1);
   assign t2_in = rnd_neg2_ff ? -TimeWidth'(sat2) : TimeWidth'(sat2);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rnd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.hit         <= rnd_hit_ff;
      rsp_data_ff.first_time  <= rnd_zero_ff ? '0 : t1_in;
      rsp_data_ff.second_time <= rnd_zero_ff ? '0 : t2_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every accepted beat comes out after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##Latency rsp_strobe)
      else $error("result beat missing after pipeline latency");

   // a miss carries zero times
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.hit |-> rsp_data.first_time == '0 && rsp_data.second_time == '0)
      else $error("miss with nonzero contact time");

   // contact times come out in ascending order
   a_order : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.first_time <= rsp_data.second_time)
      else $error("contact times out of order");

endmodule

// ----- dv/cst_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cst_checker
// Watches both channels of the swept circle test, predicts each response
// from the request beat and compares it field by field, in order.
// ----------------------------------------------------------------------------
module cst_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  cst_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  cst_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               hit_count,
   output int               timed_count
);
   import cst_pkg::*;

   rsp_type sweep_queue[$];

   // floor of num * 2^16 / a, saturated to the time range
   function automatic logic signed [TimeWidth-1:0] contact_time(longint num, longint a);
      logic          neg;
      logic [127:0]  mag;
      logic [127:0]  quo;
      logic [127:0]  rem;
      logic [127:0]  limit;
      neg   = num < 0;
      mag   = neg ? 128'(-num) : 128'(num);
      quo   = (mag << FracBits) / 128'(a);
      rem   = (mag << FracBits) % 128'(a);
      if (neg && rem != 0) quo = quo + 1;
      limit = 128'(1) << (TimeWidth - 1);
      if (!neg) limit = limit - 1;
      if (quo > limit) quo = limit;
      return neg ? -TimeWidth'(quo) : TimeWidth'(quo);
   endfunction

   // integer square root of a wide non-negative value
   function automatic longint wide_isqrt(logic [127:0] q);
      logic [63:0] r;
      logic [63:0] cand;
      r = 0;
      for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
         cand = r | (64'(1) << bit_idx);
         if (128'(cand) * 128'(cand) <= q) r = cand;
      end
      return longint'(r);
   endfunction

   // expected response for one pair of circles
   function automatic rsp_type sweep_predict(req_type b);
      rsp_type      r;
      longint       abx, aby, ab1x, ab1y, vx, vy, rab, rab2, d0, d1, a, h, hmag, c, s;
      logic [127:0] h2;
      logic [127:0] ac;
      abx  = longint'(b.b_start_x) - longint'(b.a_start_x);
      aby  = longint'(b.b_start_y) - longint'(b.a_start_y);
      ab1x = longint'(b.b_end_x) - longint'(b.a_end_x);
      ab1y = longint'(b.b_end_y) - longint'(b.a_end_y);
      vx   = ab1x - abx;
      vy   = ab1y - aby;
      rab  = longint'({1'b0, b.a_radius}) + longint'({1'b0, b.b_radius});
      rab2 = rab * rab;
      d0   = abx * abx + aby * aby;
      d1   = ab1x * ab1x + ab1y * ab1y;
      a    = vx * vx + vy * vy;
      h    = vx * abx + vy * aby;
      r    = '0;
      if (d0 <= rab2 || d1 <= rab2) begin
         r.hit = 1'b1;
         return r;
      end
      c    = d0 - rab2;
      hmag = h < 0 ? -h : h;
      h2   = 128'(hmag) * 128'(hmag);
      ac   = 128'(a) * 128'(c);
      if (a == 0 || h2 < ac) return r;
      s = wide_isqrt(h2 - ac);
      r.hit         = 1'b1;
      r.first_time  = contact_time(-h - s, a);
      r.second_time = contact_time(-h + s, a);
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count  = 0;
      hit_count   = 0;
      timed_count = 0;
   end

   assign pending = sweep_queue.size();

   // request side: predict each accepted beat
   always @(posedge clock) begin
      if (!reset && start && !busy) sweep_queue = {sweep_queue, sweep_predict(req_data)};
   end

   // response side: compare against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (sweep_queue.size() == 0) begin
            report_mismatch("response beat with nothing pending");
         end else begin
            want = sweep_queue.pop_front();
            if (want.hit) hit_count++;
            if (want.first_time != 0 || want.second_time != 0) timed_count++;
            if (rsp_data.hit != want.hit)
               report_mismatch($sformatf("hit %0b want %0b", rsp_data.hit, want.hit));
            if (rsp_data.first_time != want.first_time)
               report_mismatch($sformatf("first_time %0d want %0d",
                                         rsp_data.first_time, want.first_time));
            if (rsp_data.second_time != want.second_time)
               report_mismatch($sformatf("second_time %0d want %0d",
                                         rsp_data.second_time, want.second_time));
         end
      end
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random circle pairs into the swept collision core with
// random sender gaps and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   import cst_pkg::*;

   localparam int NumRandom  = 500;
   localparam int Latency    = 100;
   localparam int CycleLimit = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      hit_count;
   int      timed_count;
   int      cycle_count;
   int      sent_count;

   moving_circle_sweep_test_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   cst_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending),
      .hit_count(hit_count), .timed_count(timed_count)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_type pair(int ax0, int ay0, int ax1, int ay1, int ra,
                                    int bx0, int by0, int bx1, int by1, int rb);
      req_type b;
      b.a_start_x = ax0[15:0]; b.a_start_y = ay0[15:0];
      b.a_end_x   = ax1[15:0]; b.a_end_y   = ay1[15:0];
      b.a_radius  = ra[14:0];
      b.b_start_x = bx0[15:0]; b.b_start_y = by0[15:0];
      b.b_end_x   = bx1[15:0]; b.b_end_y   = by1[15:0];
      b.b_radius  = rb[14:0];
      return b;
   endfunction

   // one beat, called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(req_type b);
      req_data = b;
      start    = 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic sender_gap(bit allow);
      int n;
      if (allow && $urandom_range(0, 5) == 0) begin
         n     = $urandom_range(1, 19);
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // circles close together so that contacts are common
   function automatic req_type near_pair();
      int span;
      int cx, cy;
      span = $urandom_range(0, 3) == 0 ? 30000 : 3000;
      cx   = $urandom_range(0, 2 * 1000) - 1000;
      cy   = $urandom_range(0, 2 * 1000) - 1000;
      return pair(cx + $urandom_range(0, 2 * span) - span, cy + $urandom_range(0, 2 * span) - span,
                  cx + $urandom_range(0, 2 * span) - span, cy + $urandom_range(0, 2 * span) - span,
                  $urandom_range(0, 600),
                  cx + $urandom_range(0, 2 * span) - span, cy + $urandom_range(0, 2 * span) - span,
                  cx + $urandom_range(0, 2 * span) - span, cy + $urandom_range(0, 2 * span) - span,
                  $urandom_range(0, 600));
   endfunction

   req_type     directed[$];
   req_type     b;
   logic [191:0] raw_bits;

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      sent_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      directed = {directed, pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};                 // coincident
      directed = {directed, pair(-32768, -32768, -32768, -32768, 0,
                                 32767, 32767, 32767, 32767, 0)};                // far apart, still
      directed = {directed, pair(-32768, 0, 32767, 0, 32767, 32767, 0, -32768, 0, 32767)};
      directed = {directed, pair(-32768, -32768, 32767, 32767, 0,
                                 32767, 32767, -32768, -32768, 0)};              // full cross
      directed = {directed, pair(0, 0, 0, 0, 16, 100, 0, 100, 0, 16)};           // no motion apart
      directed = {directed, pair(0, 0, 0, 0, 16, 100, 0, 200, 0, 16)};           // moving away
      directed = {directed, pair(-1000, 0, 1000, 0, 16, 1000, 0, -1000, 0, 16)}; // head-on
      directed = {directed, pair(-1000, 0, 1000, 0, 16, 1000, 100, -1000, 100, 16)}; // near miss
      directed = {directed, pair(-1000, 0, 1000, 0, 16, 1000, 32, -1000, 32, 16)};   // grazing
      directed = {directed, pair(0, 0, 0, 0, 10, 40, 0, 0, 0, 10)};              // overlap at end
      directed = {directed, pair(0, 0, 0, 0, 0, -32768, 0, -32767, 0, 0)};       // huge positive
      directed = {directed, pair(0, 0, 0, 0, 0, 32767, 0, 32766, 0, 0)};
      directed = {directed, pair(0, 0, 0, 0, 1, 100, 0, 101, 0, 1)};             // past contact
      directed = {directed, pair(0, 0, 0, 0, 32767, 32767, 32767, -32768, -32768, 32767)};
      directed = {directed, pair(32767, 32767, 32767, 32767, 0,
                                 -32768, -32768, -32767, -32768, 0)};
      directed = {directed, pair(0, -5000, 0, 5000, 100, -5000, 0, 5000, 0, 100)};
      directed = {directed, pair(-1, -1, 1, 1, 0, 1, 1, -1, -1, 0)};
      foreach (directed[i]) send_beat(directed[i]);

      // random pairs, mostly near each other
      for (int i = 0; i < NumRandom; i++) begin
         sender_gap(i < NumRandom - 60);
         if (i == NumRandom / 2) begin
            start = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if ($urandom_range(0, 3) == 0) begin
            raw_bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            b = req_type'(raw_bits[$bits(req_type)-1:0]);
         end else begin
            b = near_pair();
         end
         send_beat(b);
      end
      start = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (Latency + 20) @(negedge clock);

      $display("tb: %0d pairs sent, %0d hits, %0d with nonzero contact times",
               sent_count, hit_count, timed_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
